[rtl/chtls_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the convex hull trick line stack.
// Used by chtls_div, chtls_mem and convex_hull_trick_line_stack.
package chtls_pkg;

  localparam int unsigned DefMaxLines = 1024;
  localparam int unsigned CoordW      = 32;
  localparam int unsigned BpW         = 35;
  localparam int unsigned ValueW      = 64;
  localparam int unsigned StatusW     = 2;

  localparam logic signed [ValueW-1:0] EmptySentinel = 64'sd1000000000000011;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK         = 2'd0,
    ST_EQ_DROPPED = 2'd1,
    ST_EQ_BETTER  = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  // Operation codes carried in the input tuser.
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } opcode_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_TOP,
    S_TOP_WAIT,
    S_DIV_RUN,
    S_PUSH,
    S_Q_CHECK,
    S_Q_WAIT,
    S_Q_LINE,
    S_Q_ADD,
    S_DONE
  } state_t;

  // One stored line with its breakpoint.
  typedef struct packed {
    logic signed [BpW-1:0]    bp;
    logic signed [CoordW-1:0] intercept;
    logic signed [CoordW-1:0] slope;
  } line_t;

  // Divider request and response.
  typedef struct packed {
    logic              start;
    logic [CoordW-1:0] dividend;
    logic [CoordW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [CoordW-1:0] quotient;
    logic [CoordW-1:0] remainder;
  } div_rsp_t;

endpackage

[rtl/chtls_div.sv]
`timescale 1ns / 1ps
// Iterative restoring divider for unsigned 32-bit operands, one quotient bit per cycle.
// Depends on chtls_pkg for the request and response structs.
module chtls_div
  import chtls_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int unsigned CntW = $clog2(CoordW + 1);

  logic              busy;
  logic              done;
  logic [CntW-1:0]   cnt;
  logic [CoordW-1:0] rem;
  logic [CoordW-1:0] quo;
  logic [CoordW-1:0] dvs;
  logic [CoordW:0]   shifted;

  // Partial remainder shifted left by one with the next dividend bit.
  assign shifted = {rem, quo[CoordW-1]};

  // Control state of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CntW'(CoordW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath: one subtract and compare per cycle.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      if (shifted >= {1'b0, dvs}) begin
        rem <= CoordW'(shifted - {1'b0, dvs});
        quo <= {quo[CoordW-2:0], 1'b1};
      end else begin
        rem <= shifted[CoordW-1:0];
        quo <= {quo[CoordW-2:0], 1'b0};
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

[rtl/chtls_mem.sv]
`timescale 1ns / 1ps
// Line store: one write port and one registered read port.
// Depends on chtls_pkg for the line_t entry type.
module chtls_mem
  import chtls_pkg::*;
#(
  parameter int unsigned MAX_LINES = DefMaxLines
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_LINES)-1:0] wr_addr,
  input  line_t                        wr_data,
  input  logic                         rd_en,
  input  logic [$clog2(MAX_LINES)-1:0] rd_addr,
  output line_t                        rd_data
);

  line_t mem [MAX_LINES];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/convex_hull_trick_line_stack.sv]
`timescale 1ns / 1ps
// Convex hull trick line stack: sequencer, line store and shared divider.
// Depends on chtls_pkg, chtls_div and chtls_mem.
//
// Input transactions arrive on s_axis: tuser is the opcode (insert or query),
// tdata packs slope, intercept and query_x. Each input gives exactly one
// output transaction on m_axis: tuser is the status, tdata the 64-bit value.
// cfg_we/cfg_wdata write max_mode (0 lower envelope, 1 upper envelope); write
// it only while the block is idle.
// One transaction is processed at a time; s_axis_tready is high only in idle.
// An insert reads the top line and runs one 32-step division in the shared
// divider for every stack line it examines, popping that line while the new
// breakpoint lies before its own; an equal slope on the top line ends the insert
// once that line is read, with no division. A query steps a binary search over
// the stored breakpoints, then reads the chosen line, multiplies and adds.
// The result becomes valid in the same cycle as the block is ready again.
// Reset empties the stack and clears max_mode; no clearing pass is needed.
// The result sits in an output register; if the receiver stalls, the block
// holds the next result until that register is free.
module convex_hull_trick_line_stack
  import chtls_pkg::*;
#(
  parameter int unsigned MAX_LINES = DefMaxLines
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // slope[31:0], intercept[63:32], query_x[95:64]
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // value[63:0]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int unsigned AW = $clog2(MAX_LINES);
  localparam int unsigned CW = $clog2(MAX_LINES + 1);

  state_t state, state_next;

  logic                     max_mode;
  logic [CW-1:0]            count;
  opcode_t                  op;
  logic signed [CoordW-1:0] a_in;
  logic signed [CoordW-1:0] b_in;
  logic signed [CoordW-1:0] x_in;
  logic signed [BpW-1:0]    top_bp;
  logic signed [BpW-1:0]    new_bp;
  logic                     n_neg;
  logic [CW-1:0]            lo;
  logic [CW-1:0]            hi;
  logic [CW-1:0]            mid;
  logic signed [ValueW-1:0] prod;
  logic signed [CoordW-1:0] q_icpt;
  status_t                  res_status;
  logic signed [ValueW-1:0] res_value;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  line_t         mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  line_t         mem_rd_data;

  logic signed [CoordW:0] n_raw;
  logic signed [CoordW:0] d_raw;
  logic signed [CoordW:0] n_norm;
  logic signed [CoordW:0] d_norm;
  logic signed [CoordW:0] n_mag;
  logic signed [BpW-1:0]  q_ext;
  logic                   r_nz;
  logic signed [BpW-1:0]  floor_q;
  logic signed [BpW-1:0]  ceil_q;
  logic [CW-1:0]          mid_calc;
  logic                   out_free;

  // Shared divider and line store.
  chtls_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  chtls_mem #(
    .MAX_LINES (MAX_LINES)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Intersection of the top line with the new line, normalized to a positive divisor.
  assign n_raw  = (CoordW+1)'(mem_rd_data.intercept) - (CoordW+1)'(b_in);
  assign d_raw  = (CoordW+1)'(a_in) - (CoordW+1)'(mem_rd_data.slope);
  assign n_norm = d_raw[CoordW] ? -n_raw : n_raw;
  assign d_norm = d_raw[CoordW] ? -d_raw : d_raw;
  assign n_mag  = n_norm[CoordW] ? -n_norm : n_norm;

  // Floor and ceiling of the signed quotient from the unsigned result.
  assign q_ext   = BpW'({1'b0, div_rsp.quotient});
  assign r_nz    = (div_rsp.remainder != '0);
  assign floor_q = n_neg ? -(q_ext + BpW'(r_nz)) : q_ext;
  assign ceil_q  = n_neg ? -q_ext : (q_ext + BpW'(r_nz));

  assign mid_calc = lo + ((hi - lo) >> 1);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign s_axis_tready = (state == S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control of the divider and the line store.
  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = n_mag[CoordW-1:0];
    div_req.divisor  = d_norm[CoordW-1:0];
    mem_rd_en        = 1'b0;
    mem_rd_addr      = AW'(count - 1'b1);
    mem_wr_en        = 1'b0;
    mem_wr_addr      = count[AW-1:0];
    mem_wr_data      = '{bp: new_bp, intercept: b_in, slope: a_in};
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (opcode_t'(s_axis_tuser) == OP_INSERT) begin
            state_next = (count == '0) ? S_PUSH : S_RD_TOP;
          end else begin
            state_next = (count == '0) ? S_DONE : S_Q_CHECK;
          end
        end
      end
      S_RD_TOP: begin
        mem_rd_en  = 1'b1;
        state_next = S_TOP_WAIT;
      end
      S_TOP_WAIT: begin
        if (mem_rd_data.slope == a_in) begin
          state_next = S_DONE;
        end else begin
          div_req.start = 1'b1;
          state_next    = S_DIV_RUN;
        end
      end
      S_DIV_RUN: begin
        if (div_rsp.done) begin
          state_next = (count > CW'(1) && floor_q < top_bp) ? S_RD_TOP : S_PUSH;
        end
      end
      S_PUSH: begin
        if (count < CW'(MAX_LINES)) begin
          mem_wr_en = 1'b1;
        end
        state_next = S_DONE;
      end
      S_Q_CHECK: begin
        mem_rd_en = 1'b1;
        if (lo < hi) begin
          mem_rd_addr = mid_calc[AW-1:0];
          state_next  = S_Q_WAIT;
        end else begin
          mem_rd_addr = AW'(lo - 1'b1);
          state_next  = S_Q_LINE;
        end
      end
      S_Q_WAIT: state_next = S_Q_CHECK;
      S_Q_LINE: state_next = S_Q_ADD;
      S_Q_ADD:  state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Configuration register and stack depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_mode <= 1'b0;
      count    <= '0;
    end else begin
      if (cfg_we) begin
        max_mode <= cfg_wdata;
      end
      if (state == S_DIV_RUN && div_rsp.done && count > CW'(1) && floor_q < top_bp) begin
        count <= count - 1'b1;
      end else if (state == S_PUSH && count < CW'(MAX_LINES)) begin
        count <= count + 1'b1;
      end
    end
  end

  // Working registers of the current transaction.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op         <= opcode_t'(s_axis_tuser);
        a_in       <= s_axis_tdata[31:0];
        b_in       <= s_axis_tdata[63:32];
        x_in       <= s_axis_tdata[95:64];
        new_bp     <= '0;
        lo         <= CW'(1);
        hi         <= count;
        res_status <= ST_OK;
        res_value  <= max_mode ? -EmptySentinel : EmptySentinel;
      end
      S_TOP_WAIT: begin
        top_bp <= mem_rd_data.bp;
        n_neg  <= n_norm[CoordW];
        if (mem_rd_data.slope == a_in) begin
          if (max_mode ? (mem_rd_data.intercept >= b_in) : (mem_rd_data.intercept <= b_in)) begin
            res_status <= ST_EQ_DROPPED;
          end else begin
            res_status <= ST_EQ_BETTER;
          end
        end
      end
      S_DIV_RUN: begin
        if (div_rsp.done) begin
          new_bp <= ceil_q;
        end
      end
      S_PUSH: begin
        res_value <= '0;
        if (count >= CW'(MAX_LINES)) begin
          res_status <= ST_FULL;
        end
      end
      S_Q_CHECK: begin
        mid <= mid_calc;
      end
      S_Q_WAIT: begin
        if (mem_rd_data.bp <= BpW'(x_in)) begin
          lo <= mid + 1'b1;
        end else begin
          hi <= mid;
        end
      end
      S_Q_LINE: begin
        prod   <= ValueW'(mem_rd_data.slope) * ValueW'(x_in);
        q_icpt <= mem_rd_data.intercept;
      end
      S_Q_ADD: begin
        res_value <= prod + ValueW'(q_icpt);
      end
      default: begin
      end
    endcase
    if (state == S_DONE && op == OP_INSERT) begin
      res_value <= res_value;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_axis_tdata <= (op == OP_INSERT) ? '0 : res_value;
      m_axis_tuser <= res_status;
    end
  end

  // The stack never holds more lines than the store.
  assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_LINES))
    else $error("line count beyond capacity");

  // The depth moves by at most one line per cycle.
  assert property (@(posedge clk) disable iff (rst)
    (count == $past(count)) || (count == $past(count) + 1'b1) ||
    (count == $past(count) - 1'b1))
    else $error("line count jumped");

  // An accepted transaction blocks the input until its result is produced.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while busy");

  // Lines are popped only while the divider reports a result.
  assert property (@(posedge clk) disable iff (rst)
    (count < $past(count)) |-> $past(div_rsp.done))
    else $error("pop without divider result");

endmodule

[test/convex_hull_trick_line_stack_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for convex_hull_trick_line_stack.
// Depends on chtls_pkg and the block; an in-bench envelope model predicts every result.
module convex_hull_trick_line_stack_test
  import chtls_pkg::*;
;

  localparam int unsigned Depth = DefMaxLines;
  localparam int unsigned WatchLimit = 400000;
  localparam int unsigned HoldLen = 300;

  typedef struct packed {
    opcode_t            op;
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic signed [31:0] qx;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic signed [63:0] value;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  convex_hull_trick_line_stack dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // Envelope model state.
  logic                model_max;
  logic signed [63:0]  env_slope [Depth];
  logic signed [63:0]  env_icpt [Depth];
  logic signed [63:0]  env_bp [Depth];
  int unsigned         env_count;

  item_t       pending_lines[$];
  outcome_t    expected_results[$];
  int          failures = 0;
  bit          calm = 1'b0;
  bit          hold_start = 1'b0;
  int unsigned hold_cycles = 0;
  int          idle_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Appends one item to the stimulus queue.
  function automatic void add_item(item_t it);
    pending_lines.insert(pending_lines.size(), it);
  endfunction

  function automatic logic signed [63:0] floor_quot(logic signed [63:0] n,
                                                     logic signed [63:0] d);
    logic signed [63:0] q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic signed [63:0] ceil_quot(logic signed [63:0] n,
                                                    logic signed [63:0] d);
    logic signed [63:0] q;
    q = n / d;
    if ((n % d) != 0 && n > 0) q = q + 1;
    return q;
  endfunction

  function automatic status_t insert_line(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] bp, n, d, ta, tb;
    int unsigned t;
    bp = 0;
    while (env_count > 0) begin
      t = env_count - 1;
      ta = env_slope[t];
      tb = env_icpt[t];
      if (ta == a) begin
        if (model_max ? (tb >= b) : (tb <= b)) return ST_EQ_DROPPED;
        return ST_EQ_BETTER;
      end
      n = tb - b;
      d = a - ta;
      if (d < 0) begin
        n = -n;
        d = -d;
      end
      bp = ceil_quot(n, d);
      if (t > 0 && floor_quot(n, d) < env_bp[t]) env_count--;
      else break;
    end
    if (env_count >= Depth) return ST_FULL;
    if (env_count == 0) bp = 0;
    env_slope[env_count] = a;
    env_icpt[env_count] = b;
    env_bp[env_count] = bp;
    env_count++;
    return ST_OK;
  endfunction

  function automatic logic signed [63:0] envelope_at(logic signed [63:0] x);
    int unsigned lo, hi, mid;
    if (env_count == 0) return model_max ? -EmptySentinel : EmptySentinel;
    lo = 1;
    hi = env_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (env_bp[mid] <= x) lo = mid + 1;
      else hi = mid;
    end
    return env_slope[lo-1] * x + env_icpt[lo-1];
  endfunction

  // Driver: offers the oldest pending item, idling at random unless calm.
  always @(posedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_lines.size() > 0 && (calm || $urandom_range(99) >= 23)) begin
          item_t it;
          outcome_t oc;
          it = pending_lines.pop_front();
          oc.value = 0;
          oc.status = ST_OK;
          if (it.op == OP_INSERT) oc.status = insert_line(it.slope, it.intercept);
          else oc.value = envelope_at(it.qx);
          expected_results.insert(expected_results.size(), oc);
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= it.op;
          s_axis_tdata <= {it.qx, it.intercept, it.slope};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result transaction with the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result status=%0d value=%0d", m_axis_tuser,
                 $signed(m_axis_tdata));
          failures++;
        end else begin
          outcome_t oc;
          oc = expected_results.pop_front();
          if (m_axis_tuser !== oc.status) begin
            $error("status: expected %0d, actual %0d", oc.status, m_axis_tuser);
            failures++;
          end
          if (m_axis_tdata !== oc.value) begin
            $error("value: expected %0d, actual %0d", oc.value, $signed(m_axis_tdata));
            failures++;
          end
        end
      end
    end
  end

  // Receiver: random backpressure, and one long hold-off once it is requested.
  always @(posedge clk) begin
    if (!rst) begin
      if (hold_start && hold_cycles < HoldLen) begin
        hold_cycles <= hold_cycles + 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 23);
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (!rst && (s_axis_tvalid || expected_results.size() > 0)) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic item_t make_insert(logic signed [31:0] a, logic signed [31:0] b);
    item_t it;
    it.op = OP_INSERT;
    it.slope = a;
    it.intercept = b;
    it.qx = $urandom;
    return it;
  endfunction

  function automatic item_t make_query(logic signed [31:0] x);
    item_t it;
    it.op = OP_QUERY;
    it.slope = $urandom;
    it.intercept = $urandom;
    it.qx = x;
    return it;
  endfunction

  // Waits until the block has drained, then writes the mode register.
  task automatic set_mode(logic m);
    wait (pending_lines.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
    repeat (5) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    model_max = m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed run: slopes strictly monotone in the order the mode needs, broken at random now and then.
  task automatic queue_run(int n, int span);
    logic signed [31:0] a;
    a = model_max ? -$signed(32'($urandom_range(span))) : $signed(32'($urandom_range(span)));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) a = $urandom; // broken order, occasionally
      add_item(make_insert(a, $signed(32'($urandom_range(4000))) - 2000));
      if ($urandom_range(3) == 0) add_item(make_query($urandom));
      add_item(make_query($signed(32'($urandom_range(200))) - 100));
      a = model_max ? a + $signed(32'($urandom_range(3, 1))) : a - $signed(32'($urandom_range(3, 1)));
    end
  endtask

  initial begin
    model_max = 1'b0;
    env_count = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty queries, extremes, equal slopes, both modes.
    add_item(make_query(32'sh80000000));
    add_item(make_insert(32'sh7fffffff, 32'sh80000000));
    add_item(make_insert(32'sh7fffffff, 32'sh7fffffff));
    add_item(make_insert(32'sh7fffffff, 32'sh80000000));
    add_item(make_insert(0, 0));
    add_item(make_insert(32'sh80000000, 32'sh7fffffff));
    add_item(make_insert(32'sh80000000, 32'sh80000000));
    add_item(make_query(32'sh7fffffff));
    add_item(make_query(32'sh80000000));
    add_item(make_query(0));
    add_item(make_query(32'shffffffff));
    set_mode(1'b1);
    add_item(make_query(5));
    add_item(make_insert(32'sh80000000, 32'sh80000000));
    add_item(make_insert(32'sh80000000, 32'sh7fffffff));
    add_item(make_insert(32'sh80000000, 32'sh80000000));
    add_item(make_insert(32'sh7fffffff, 0));
    add_item(make_query(32'sh7fffffff));
    add_item(make_query(32'sh80000000));
    set_mode(1'b0);
    env_count = env_count; // stack kept across a mode change
    add_item(make_query(-3));

    // Fill the stack to its limit with a long calm run and a receiver hold-off.
    calm = 1'b1;
    hold_start = 1'b1;
    for (int i = 0; i < 1030; i++)
      add_item(make_insert(-2000000 - i * 3, i * i));
    add_item(make_query(100));
    set_mode(1'b0);
    calm = 1'b0;

    // Random phases: fresh stacks are not possible, so runs pile up and pop.
    for (int phase = 0; phase < 4; phase++) begin
      set_mode(phase[0]);
      queue_run(100, phase < 2 ? 60 : 2000000000);
      for (int k = 0; k < 20; k++) add_item(make_insert($urandom, $urandom));
      for (int k = 0; k < 20; k++) add_item(make_query($urandom));
    end

    wait (pending_lines.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (failures == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[filelist.f]
rtl/chtls_pkg.sv
rtl/chtls_div.sv
rtl/chtls_mem.sv
rtl/convex_hull_trick_line_stack.sv
test/convex_hull_trick_line_stack_test.sv
